FILE: sv/i2a_pkg.sv
// types, constants and digit-to-character map shared by the itoa block
`default_nettype none

package i2a_pkg;

  localparam int IN_W         = 32;
  localparam int RADIX_W      = 6;
  localparam int DIGIT_W      = 5;
  localparam int CHAR_W       = 8;
  // quotient bits resolved per cycle by the divider
  localparam int BITS_PER_CYC = 8;

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam radix_t MIN_RADIX  = 6'd2;
  localparam radix_t MAX_RADIX  = 6'd32;
  localparam radix_t RADIX_TEN  = 6'd10;
  localparam digit_t DIGIT_TEN  = 5'd10;

  localparam char_t DIGIT_BASE_CHAR  = 8'd48;
  localparam char_t LETTER_BASE_CHAR = 8'd65;
  localparam char_t MINUS_CHAR       = 8'd45;
  localparam char_t NUL_CHAR         = 8'd0;

  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_stat_t;

  function automatic char_t digit_char(input digit_t d);
    char_t c;
    if (d >= DIGIT_TEN) begin
      c = LETTER_BASE_CHAR + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = DIGIT_BASE_CHAR + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/i2a_divider.sv
// iterative divide by radix, several quotient bits per cycle, one digit per run
`default_nettype none

module i2a_divider
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire radix_t                radix,
  output logic [VALUE_BITS-1:0]      quotient,
  output digit_t                     digit,
  output div_stat_t                  stat
);

  localparam int NSTEP = (VALUE_BITS + BITS_PER_CYC - 1) / BITS_PER_CYC;
  localparam int PAD_W = NSTEP * BITS_PER_CYC;
  localparam int CNT_W = $clog2(NSTEP + 1);

  logic [PAD_W-1:0]        work_r, work_nxt;
  digit_t                  rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r, done_r;
  logic [BITS_PER_CYC-1:0] qbits;
  radix_t                  trial;

  // restoring division over the top bits of the working word
  always_comb begin
    rem_nxt = rem_r;
    qbits   = '0;
    trial   = '0;
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      trial = {rem_nxt, work_r[PAD_W-1-k]};
      if (trial >= radix) begin
        trial = trial - radix;
        qbits[BITS_PER_CYC-1-k] = 1'b1;
      end
      rem_nxt = trial[DIGIT_W-1:0];
    end
    work_nxt = (work_r << BITS_PER_CYC) | PAD_W'(qbits);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(NSTEP - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        work_r <= PAD_W'(dividend);
        rem_r  <= '0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 1'b1;
        work_r <= work_nxt;
        rem_r  <= rem_nxt;
        if (cnt_r == CNT_W'(NSTEP - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign quotient      = work_r[VALUE_BITS-1:0];
  assign digit         = rem_r;
  assign stat.done     = done_r;
  assign stat.quo_zero = (work_r == '0);

endmodule

`default_nettype wire

FILE: sv/integer_to_ascii_radix.sv
// integer to ascii digit string, radix 2 to 32, one character per output word
//
//  channel | direction | ports                                    | handshake
//  --------+-----------+------------------------------------------+-----------------------
//  in      | input     | in_value[31:0] signed, in_radix[5:0]     | in_valid / in_ready
//  out     | output    | out_char_code[7:0], out_last, out_bad_radix | out_valid / out_ready
//
// each digit comes from the shared divider, which is restarted on its own quotient;
// digits are stacked lsb first and then emitted msb first, each character passing
// through S_RD and S_OUT; a minus sign, if any, goes out ahead of the digits.
// in_ready is high only in idle; the output register lets a new word in while the
// previous result still waits. rst_n is synchronous; the digit stack needs no clearing.
`default_nettype none

module integer_to_ascii_radix
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [IN_W-1:0] in_value,
  input  wire radix_t            in_radix,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output char_t                  out_char_code,
  output logic                   out_last,
  output logic                   out_bad_radix
);

  localparam int ADDR_W = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAD,
    S_DIV,
    S_SIGN,
    S_RD,
    S_OUT
  } state_t;

  state_t                  state_r;
  radix_t                  radix_r;
  logic                    neg_r;
  logic [ADDR_W-1:0]       wr_addr_r, idx_r;
  digit_t                  rd_data_r;
  logic                    out_valid_r, out_last_r, out_bad_r;
  char_t                   out_char_r;

  logic                    accept, bad_in, neg_in, out_free, div_start, wr_en;
  logic                    out_load;
  logic [VALUE_BITS-1:0]   val_ext, mag_in, div_dividend, quotient;
  digit_t                  digit;
  div_stat_t               div_stat;
  digit_t                  stack_mem [VALUE_BITS];

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign bad_in   = (in_radix < MIN_RADIX) || (in_radix > MAX_RADIX);
  assign val_ext  = VALUE_BITS'(in_value);
  assign neg_in   = (in_radix == RADIX_TEN) && val_ext[VALUE_BITS-1];
  assign mag_in   = neg_in ? (~val_ext + 1'b1) : val_ext;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free && (state_r inside {S_BAD, S_SIGN, S_OUT});
  assign wr_en    = (state_r == S_DIV) && div_stat.done;

  // start the divider on the magnitude at accept, then restart it on its own quotient until it reaches zero
  assign div_start    = (accept && !bad_in) || (wr_en && !div_stat.quo_zero);
  assign div_dividend = (state_r == S_IDLE) ? mag_in : quotient;

  i2a_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (radix_r),
    .quotient (quotient),
    .digit    (digit),
    .stat     (div_stat)
  );

  // digit stack
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr_r] <= digit;
    end
    rd_data_r <= stack_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            radix_r   <= in_radix;
            neg_r     <= neg_in;
            wr_addr_r <= '0;
            state_r   <= bad_in ? S_BAD : S_DIV;
          end
        end
        S_BAD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= NUL_CHAR;
            out_last_r  <= 1'b1;
            out_bad_r   <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (div_stat.quo_zero) begin
              idx_r   <= wr_addr_r;
              state_r <= neg_r ? S_SIGN : S_RD;
            end else begin
              wr_addr_r <= wr_addr_r + 1'b1;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= MINUS_CHAR;
            out_last_r  <= 1'b0;
            out_bad_r   <= 1'b0;
            state_r     <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= digit_char(rd_data_r);
            out_last_r  <= (idx_r == '0);
            out_bad_r   <= 1'b0;
            if (idx_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r - 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign out_bad_radix = out_bad_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside digit generation");

  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_radix |-> out_last && out_char_code == NUL_CHAR)
    else $error("bad radix word is not a single terminal nul");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_bad_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_radix < MIN_RADIX || in_radix > MAX_RADIX)
      |=> state_r == S_BAD)
    else $error("invalid radix did not take the error path");

endmodule

`default_nettype wire
